// ===== rtl/dip_pkg.sv =====
`default_nettype none

package dip_pkg;

  // Longest number run before the parser closes it, capped by the 16-bit count.
  localparam int unsigned MAX_LEN = 65535;
  localparam int unsigned LEN_CAP = (MAX_LEN > 65535) ? 65535 : MAX_LEN;

  localparam int CNT_W      = 16;
  localparam int VAL_W      = 64;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] LEN_CAP_C = CNT_W'(LEN_CAP);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 4'd1;

  typedef enum logic [1:0] {
    WM_8  = 2'd0,
    WM_16 = 2'd1,
    WM_32 = 2'd2,
    WM_64 = 2'd3
  } width_mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_DIGITS = 4'b0010,
    PH_OVFL   = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_e;

  typedef struct packed {
    width_mode_e width_mode;
    logic        signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] magnitude;
    logic             negate;
    width_mode_e      width_mode;
    logic [CNT_W-1:0] consumed;
    status_e          status;
  } raw_result_t;

  function automatic logic [VAL_W-1:0] width_mask(width_mode_e mode);
    logic [VAL_W-1:0] m;
    case (mode)
      WM_8:    m = 64'h0000_0000_0000_00FF;
      WM_16:   m = 64'h0000_0000_0000_FFFF;
      WM_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dip_char_if.sv =====
`default_nettype none

interface dip_char_if;
  logic                      valid;
  logic                      ready;
  logic [dip_pkg::CHAR_W-1:0] ch;
  logic                      last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/dip_result_if.sv =====
`default_nettype none

interface dip_result_if;
  logic                      valid;
  logic                      ready;
  logic [dip_pkg::VAL_W-1:0] value;
  logic [dip_pkg::CNT_W-1:0] consumed;
  logic [1:0]                status;

  modport source (output valid, value, consumed, status, input ready);
  modport sink   (input valid, value, consumed, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/dip_cfg_if.sv =====
`default_nettype none

interface dip_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dip_pkg::CFG_IDX_W-1:0]  index;
  logic [dip_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/dip_core.sv =====
`default_nettype none

module dip_core (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  dip_char_if.sink             char_i,
  input  dip_pkg::cfg_t        cfg_i,
  output dip_pkg::raw_result_t raw_o,
  output logic                 raw_valid_o,
  input  wire                  raw_ready_i
);

  // Input register.
  logic                       a_valid_q;
  logic [dip_pkg::CHAR_W-1:0] a_ch_q;
  logic                       a_last_q;

  // Parser state.
  dip_pkg::phase_e            phase_q, phase_d;
  logic [dip_pkg::VAL_W-1:0]  acc_q, acc_d;
  logic [dip_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                       minus_q, minus_d;

  // Result register, before sign and width are applied.
  logic                       b_valid_q;
  dip_pkg::raw_result_t       b_q, b_d;

  logic                       b_ready;
  logic                       a_adv;

  assign b_ready      = !b_valid_q || raw_ready_i;
  assign a_adv        = a_valid_q && b_ready;
  assign char_i.ready = !a_valid_q || b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      a_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      a_ch_q   <= char_i.ch;
      a_last_q <= char_i.last;
    end
  end

  logic [dip_pkg::VAL_W-1:0]   mask;
  logic [dip_pkg::VAL_W-1:0]   lim;
  logic                        is_minus;
  logic                        is_numeral;
  logic [dip_pkg::VAL_W+3:0]   prod;
  logic                        digit_ovf;
  logic                        old_over;
  logic [dip_pkg::CNT_W-1:0]   cnt_inc;

  assign mask = dip_pkg::width_mask(cfg_i.width_mode);
  assign lim  = cfg_i.signed_mode ? ((mask >> 1) + {63'd0, minus_q}) : mask;

  assign is_minus = (phase_q == dip_pkg::PH_START) && cfg_i.signed_mode
                    && (a_ch_q == dip_pkg::CHAR_MINUS);
  assign is_numeral = (a_ch_q >= dip_pkg::CHAR_ZERO) && (a_ch_q <= dip_pkg::CHAR_NINE);

  // Ten times the accumulator plus the digit, kept wide so that the range check is exact.
  // The digit is the low nibble since the code for zero has a clear low nibble.
  assign prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, a_ch_q[3:0]};
  assign digit_ovf = prod > {4'd0, lim};
  assign old_over  = acc_q > lim;
  assign cnt_inc   = cnt_q + 16'd1;

  dip_pkg::phase_e           upd_phase;
  logic [dip_pkg::VAL_W-1:0] upd_acc;
  logic [dip_pkg::CNT_W-1:0] upd_cnt;
  logic                      upd_minus;
  logic                      done;
  logic                      no_dig;
  logic                      over;

  always_comb begin
    upd_phase = phase_q;
    upd_acc   = acc_q;
    upd_cnt   = cnt_q;
    upd_minus = minus_q;
    done      = 1'b0;

    if (phase_q == dip_pkg::PH_SKIP) begin
      done = 1'b0;
    end else if (is_minus) begin
      upd_minus = 1'b1;
      upd_cnt   = 16'd1;
      upd_phase = dip_pkg::PH_DIGITS;
      done      = a_last_q || (dip_pkg::LEN_CAP_C <= 16'd1);
    end else if (is_numeral) begin
      upd_cnt = cnt_inc;
      if (phase_q != dip_pkg::PH_OVFL) begin
        if (digit_ovf) begin
          upd_phase = dip_pkg::PH_OVFL;
        end else begin
          upd_acc   = prod[dip_pkg::VAL_W-1:0];
          upd_phase = dip_pkg::PH_DIGITS;
        end
      end
      done = a_last_q || (cnt_inc >= dip_pkg::LEN_CAP_C);
    end else begin
      done = 1'b1;
    end

    // A digit that stays in range leaves the accumulator within the limit, so only a
    // number closed by another character needs the stored value checked again.
    no_dig = (upd_cnt == {15'd0, upd_minus});
    over   = (upd_phase == dip_pkg::PH_OVFL) || (!is_numeral && old_over);

    b_d.width_mode = cfg_i.width_mode;
    if (no_dig) begin
      b_d.magnitude = '0;
      b_d.negate    = 1'b0;
      b_d.consumed  = '0;
      b_d.status    = dip_pkg::ST_NO_DIGITS;
    end else if (over) begin
      b_d.magnitude = '0;
      b_d.negate    = 1'b0;
      b_d.consumed  = upd_cnt;
      b_d.status    = dip_pkg::ST_OVERFLOW;
    end else begin
      b_d.magnitude = upd_acc;
      b_d.negate    = upd_minus;
      b_d.consumed  = upd_cnt;
      b_d.status    = dip_pkg::ST_OK;
    end

    phase_d = upd_phase;
    acc_d   = upd_acc;
    cnt_d   = upd_cnt;
    minus_d = upd_minus;
    if (a_last_q) begin
      phase_d = dip_pkg::PH_START;
      acc_d   = '0;
      cnt_d   = '0;
      minus_d = 1'b0;
    end else if (done) begin
      phase_d = dip_pkg::PH_SKIP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dip_pkg::PH_START;
      acc_q   <= '0;
      cnt_q   <= '0;
      minus_q <= 1'b0;
    end else if (a_adv) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      minus_q <= minus_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_adv && done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && done) begin
      b_q <= b_d;
    end
  end

  assign raw_o       = b_q;
  assign raw_valid_o = b_valid_q;

  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv && (phase_q == dip_pkg::PH_SKIP) |=> !b_valid_q)
    else $error("a skipped character produced a result");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_adv && a_last_q |=> (phase_q == dip_pkg::PH_START) && (cnt_q == 16'd0))
    else $error("parser did not return to the start after the last character");

  a_count_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == dip_pkg::PH_DIGITS) || (phase_q == dip_pkg::PH_OVFL) |-> cnt_q != 16'd0)
    else $error("number run with an empty character count");

  a_raw_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !raw_ready_i |=> b_valid_q && $stable(b_q))
    else $error("stalled result changed before its transfer");

endmodule

`default_nettype wire

// ===== rtl/dip_emit.sv =====
`default_nettype none

module dip_emit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  dip_pkg::raw_result_t raw_i,
  input  wire                  raw_valid_i,
  output logic                 raw_ready_o,
  dip_result_if.source         result_o
);

  logic                      o_valid_q;
  logic [dip_pkg::VAL_W-1:0] value_q, value_d;
  logic [dip_pkg::CNT_W-1:0] consumed_q;
  logic [1:0]                status_q;
  logic [dip_pkg::VAL_W-1:0] signed_val;

  assign raw_ready_o = !o_valid_q || result_o.ready;

  // Negative results are the two's complement, cut to the selected width.
  assign signed_val = raw_i.negate ? (64'd0 - raw_i.magnitude) : raw_i.magnitude;
  assign value_d    = signed_val & dip_pkg::width_mask(raw_i.width_mode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (raw_ready_o) begin
      o_valid_q <= raw_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_valid_i && raw_ready_o) begin
      value_q    <= value_d;
      consumed_q <= raw_i.consumed;
      status_q   <= raw_i.status;
    end
  end

  assign result_o.valid    = o_valid_q;
  assign result_o.value    = value_q;
  assign result_o.consumed = consumed_q;
  assign result_o.status   = status_q;

endmodule

`default_nettype wire

// ===== rtl/decimal_integer_parser_unit.sv =====
// A closing character passes the input register; its result then moves through the
// result register and the output register.
// Throughput: one character per cycle unless the output stalls, set by the single
// multiply-by-ten, add and compare between the input register and the result register.
// Reset clears the pipeline, puts the parser at the start of a string and sets the
// width to 64 bits, unsigned.
`default_nettype none

module decimal_integer_parser_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  dip_char_if.sink     char_i,
  dip_result_if.source result_o,
  dip_cfg_if.sink      cfg_i
);

  dip_pkg::width_mode_e width_mode_q;
  logic                 signed_mode_q;
  dip_pkg::cfg_t        cfg;
  dip_pkg::raw_result_t raw;
  logic                 raw_valid;
  logic                 raw_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_mode_q  <= dip_pkg::WM_64;
      signed_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dip_pkg::REG_WIDTH_MODE: begin
          width_mode_q <= dip_pkg::width_mode_e'(cfg_i.data[1:0]);
        end
        dip_pkg::REG_SIGNED_MODE: begin
          signed_mode_q <= cfg_i.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.width_mode  = width_mode_q;
  assign cfg.signed_mode = signed_mode_q;

  dip_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (char_i),
    .cfg_i       (cfg),
    .raw_o       (raw),
    .raw_valid_o (raw_valid),
    .raw_ready_i (raw_ready)
  );

  dip_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .raw_i       (raw),
    .raw_valid_i (raw_valid),
    .raw_ready_o (raw_ready),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
